// ----- hw/rtl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the mode value tracker: table geometry,
// field widths, entry layout, sequencer states and the update record.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int VALUE_W       = 30;
   localparam int COUNT_W       = 20;
   localparam int EPOCH_W       = 4;
   localparam int ENTRY_W       = EPOCH_W + VALUE_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
   localparam logic [ADDR_W-1:0]  ADDR_LAST   = ADDR_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [VALUE_W-1:0] key;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic               valid;
      logic               first;
      logic               full;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } upd_type;

endpackage

// ----- hw/rtl/mvt_ram.sv -----
// ----------------------------------------------------------------------------
// mvt_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mvt_table.sv -----
// ----------------------------------------------------------------------------
// mvt_table
// Hash table sequencer: takes a request, walks the table by linear probing,
// then writes back the new or incremented entry unless the table is full.
// Slots carry an epoch mark; a first mark starts a new epoch, and a sweep
// zeroes all marks after reset and whenever the epoch wraps.
// ----------------------------------------------------------------------------
module mvt_table
   import mvt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_sample_value,
   input  logic               req_first,
   input  logic               out_ready,
   output upd_type            upd
);

   state_type          state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               first_ff, first_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               full_ff, full_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   logic [ADDR_W-1:0]  slot_next;

   mvt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign slot_next = (slot_ff == ADDR_LAST) ? '0 : slot_ff + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         epoch_ff <= EPOCH_FIRST;
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      step_ff  <= step_in;
      value_ff <= value_in;
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
      full_ff  <= full_in;
   end

   always_comb begin
      state_in = state_ff;
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      pend_in  = pend_ff;
      slot_in  = slot_ff;
      step_in  = step_ff;
      value_in = value_ff;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      full_in  = full_ff;
      req_stall = 1'b1;
      wr_en    = 1'b0;
      wr_addr  = slot_ff;
      wr_entry = '{epoch: epoch_ff, key: value_ff, count: cnt_ff};
      rd_en    = 1'b0;
      rd_addr  = slot_ff;
      upd      = '{valid: 1'b0, first: first_ff, full: full_ff,
                   value: value_ff, count: cnt_ff};

      unique case (state_ff)
         ST_SWEEP: begin
            // zero the epoch mark of one slot per cycle
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_entry = '{epoch: EPOCH_NONE, key: '0, count: '0};
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_LAST) begin
               sweep_in = '0;
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_PROBE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               value_in = req_sample_value;
               first_in = req_first;
               slot_in  = req_sample_value[ADDR_W-1:0];
               step_in  = '0;
               state_in = ST_PROBE;
               if (req_first) begin
                  if (epoch_ff == EPOCH_LAST) begin
                     epoch_in = EPOCH_FIRST;
                     pend_in  = 1'b1;
                     state_in = ST_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end
         end
         ST_PROBE: begin
            rd_en    = 1'b1;
            rd_addr  = slot_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            full_in = 1'b0;
            if (rd_entry.epoch != epoch_ff) begin
               cnt_in   = COUNT_W'(1);
               state_in = ST_WRITE;
            end else if (rd_entry.key == value_ff) begin
               cnt_in   = (rd_entry.count == COUNT_MAX) ? COUNT_MAX
                                                        : rd_entry.count + COUNT_W'(1);
               state_in = ST_WRITE;
            end else if (step_ff == ADDR_LAST) begin
               full_in  = 1'b1;
               state_in = ST_WRITE;
            end else begin
               // advance to the next slot and read it right away
               slot_in  = slot_next;
               step_in  = step_ff + ADDR_W'(1);
               rd_en    = 1'b1;
               rd_addr  = slot_next;
            end
         end
         ST_WRITE: begin
            if (out_ready) begin
               upd.valid = 1'b1;
               wr_en     = !full_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/mvt_best.sv -----
// ----------------------------------------------------------------------------
// mvt_best
// Mode tracker and response register: folds each entry update into the
// current mode (smaller value wins a tie) and presents the response.
// ----------------------------------------------------------------------------
module mvt_best
   import mvt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  upd_type            upd,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0] rsp_mode_count,
   output logic               rsp_table_full
);

   logic [VALUE_W-1:0] best_value_ff, best_value_in;
   logic [COUNT_W-1:0] best_count_ff, best_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               full_ff, full_in;
   logic [VALUE_W-1:0] base_value;
   logic [COUNT_W-1:0] base_count;
   logic               better;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign base_value = upd.first ? '0 : best_value_ff;
   assign base_count = upd.first ? '0 : best_count_ff;
   assign better     = !upd.full && ((upd.count > base_count) ||
                       ((upd.count == base_count) && (upd.value < base_value)));

   always_comb begin
      best_value_in = best_value_ff;
      best_count_in = best_count_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (upd.valid) begin
         rsp_valid_in  = 1'b1;
         full_in       = upd.full;
         best_value_in = better ? upd.value : base_value;
         best_count_in = better ? upd.count : base_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_value_ff <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         best_value_ff <= best_value_in;
         best_count_ff <= best_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      full_ff <= full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = best_value_ff;
   assign rsp_mode_count = best_count_ff;
   assign rsp_table_full = full_ff;

endmodule

// ----- hw/rtl/mode_value_tracker.sv -----
// ----------------------------------------------------------------------------
// mode_value_tracker
// Streaming mode finder: counts each requested value in a linear-probing
// hash table and responds with the current mode and its count.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  sample_value[29:0], first
//   rsp      out        rsp_valid/rsp_stall  mode_value[29:0], mode_count[19:0],
//                                            table_full
//
// A request passes through PROBE, CHECK and WRITE when its value sits in its
// home slot, and each further slot probed (up to all 1024 on a full table)
// adds another CHECK step, since the table memory has a single read port.
// After reset a sweep over all 1024 slots clears the table before the first
// request is taken; every 15th first mark starts the same sweep.
// A response held by rsp_stall holds the write-back of the next request.
// ----------------------------------------------------------------------------
module mode_value_tracker
   import mvt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_sample_value,
   input  logic               req_first,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0] rsp_mode_count,
   output logic               rsp_table_full
);

   upd_type upd;
   logic    out_ready;

   mvt_table u_table (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_value(req_sample_value),
      .req_first       (req_first),
      .out_ready       (out_ready),
      .upd             (upd)
   );

   mvt_best u_best (
      .clock         (clock),
      .reset         (reset),
      .upd           (upd),
      .out_ready     (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_mode_value(rsp_mode_value),
      .rsp_mode_count(rsp_mode_count),
      .rsp_table_full(rsp_table_full)
   );

   a_upd_slot_free: assert property (@(posedge clock) disable iff (reset)
      upd.valid |-> out_ready)
      else $error("update issued while response slot is held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new request taken while previous one is in flight");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_table_full) |-> (rsp_mode_count != '0))
      else $error("counted request reports a zero mode count");

   a_first_counts: assert property (@(posedge clock) disable iff (reset)
      (upd.valid && upd.first) |-> !upd.full)
      else $error("first request of a new set found the table full");

endmodule
